FILE: src/rsa_pkg.sv
// Shared types and constants for the register slot allocator.
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int NUM_VREGS    = 17;
  localparam int VREG_W       = 5;
  localparam int FIELD_W      = 5;
  localparam int PHYS_END     = 7;
  localparam int PHYS_W       = 3;
  localparam int LOW_TEMP_END = 5;

  typedef enum logic [2:0] {
    CMD_MAP        = 3'd0,
    CMD_UNMAP      = 3'd1,
    CMD_UNLOCK_ALL = 3'd2,
    CMD_TEMP_ANY   = 3'd3,
    CMD_TEMP_LOW   = 3'd4,
    CMD_RESERVE    = 3'd5,
    CMD_START_BLK  = 3'd6,
    CMD_QUERY      = 3'd7
  } rsa_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } rsa_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [VREG_W-1:0]  virtual_reg;
    logic               for_reading;
    logic [FIELD_W-1:0] fixed_slot;
    logic               keep_modified;
  } rsa_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] slot_index;
    logic               is_physical;
    logic               use_backup;
    logic               found;
    logic               in_use;
    logic [FIELD_W-1:0] initial_slot;
    logic               modified;
    logic [FIELD_W-1:0] max_used;
  } rsa_out_t;

  // Write and clear control for the map memory.
  typedef struct packed {
    logic              wr_en;
    logic [VREG_W-1:0] wr_addr;
    logic              clr;
  } rsa_mem_ctl_t;

endpackage

FILE: src/rsa_map_mem.sv
// Map memory: per virtual register the mapped slot and the initial slot.
`timescale 1ns / 1ps

module rsa_map_mem #(
  parameter int SLOT_W = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [rsa_pkg::VREG_W-1:0] rd_addr,
  output logic [2*SLOT_W-1:0]   rd_data,
  input  rsa_pkg::rsa_mem_ctl_t ctl,
  input  logic [2*SLOT_W-1:0]   wr_data
);
  import rsa_pkg::*;

  localparam int ENT_W = 2 * SLOT_W;

  logic [ENT_W-1:0]     mem [NUM_VREGS];
  logic [NUM_VREGS-1:0] valid_r;
  logic [ENT_W-1:0]     rd_q_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entries never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

FILE: src/rsa_slot_scan.sv
// First free memory slot search, split into a registered group stage and a group pick.
`timescale 1ns / 1ps

module rsa_slot_scan #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 5
) (
  input  logic              clk,
  input  logic              load,
  input  logic [NUM_SLOTS:0] occ,
  output logic              hit,
  output logic [SLOT_W-1:0] slot
);
  import rsa_pkg::*;

  localparam int NSL  = NUM_SLOTS + 1;
  localparam int NGRP = (NSL + 7) / 8;

  logic [NGRP*8-1:0] free_pad;
  logic [NGRP-1:0]   any_nxt;
  logic [NGRP-1:0]   any_r;
  logic [2:0]        idx_nxt [NGRP];
  logic [2:0]        idx_r   [NGRP];

  // Physical slots and padding never count as free here.
  always_comb begin
    free_pad = '0;
    for (int i = PHYS_END; i < NSL; i++) begin
      free_pad[i] = !occ[i];
    end
    for (int g = 0; g < NGRP; g++) begin
      any_nxt[g] = 1'b0;
      idx_nxt[g] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (free_pad[g*8 + j]) begin
          any_nxt[g] = 1'b1;
          idx_nxt[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      any_r <= any_nxt;
      for (int g = 0; g < NGRP; g++) begin
        idx_r[g] <= idx_nxt[g];
      end
    end
  end

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        hit  = 1'b1;
        slot = SLOT_W'(g*8 + int'(idx_r[g]));
      end
    end
  end

endmodule

FILE: src/register_slot_allocator_top.sv
// Register slot allocator: command sequencer, slot state and result register.
// The result strobe is registered from the execute state, which follows the scan state after a start.
// A new command is taken only in the idle state; the map memory read and the
// registered free-slot group search both complete before the update in the execute state.
// Reset: synchronous, active low; all maps, locks, marks and the highest slot clear.
// Results are shown for one cycle only; the receiver cannot stall them.
`timescale 1ns / 1ps

module register_slot_allocator_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rsa_pkg::rsa_in_t  in_item,
  output logic              out_valid,
  output rsa_pkg::rsa_out_t out_item
);
  import rsa_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS + 1);

  rsa_state_t state_r, state_nxt;
  rsa_in_t    item_r;
  logic       accept;

  logic [NUM_SLOTS:0]  occ_r, occ_nxt;
  logic [NUM_SLOTS:0]  used_r, used_nxt;
  logic [NUM_SLOTS:0]  mod_r, mod_nxt;
  logic [PHYS_END-1:0] lv_r, lv_nxt;
  logic [PHYS_END-1:0] lt_r, lt_nxt;
  logic [SLOT_W-1:0]   high_r, high_nxt;

  rsa_out_t res;
  rsa_out_t out_item_r;
  logic     out_valid_r;

  rsa_mem_ctl_t        mem_ctl;
  logic [2*SLOT_W-1:0] mem_rd_data;
  logic [2*SLOT_W-1:0] mem_wr_data;
  logic [SLOT_W-1:0]   ent_map;
  logic [SLOT_W-1:0]   ent_init;

  logic              mf_hit;
  logic [SLOT_W-1:0] mf_slot;

  logic              vok;
  logic              s_phys;
  logic [PHYS_W-1:0] s_p;
  logic              fs_ok;
  logic              fs_phys;
  logic [SLOT_W-1:0] fs_i;
  logic [PHYS_W-1:0] fs_p;

  logic              pf_hit;
  logic [PHYS_W-1:0] pf_idx;
  logic              t1_hit, t2_hit;
  logic [PHYS_W-1:0] t1_idx, t2_idx;
  int                t_last;

  logic              claim_hit;
  logic [SLOT_W-1:0] claim_slot;
  logic [SLOT_W-1:0] init_new;
  logic              temp_hit;
  logic [PHYS_W-1:0] temp_idx;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  rsa_map_mem #(
    .SLOT_W (SLOT_W)
  ) u_map_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && (int'(in_item.virtual_reg) < NUM_VREGS)),
    .rd_addr (in_item.virtual_reg),
    .rd_data (mem_rd_data),
    .ctl     (mem_ctl),
    .wr_data (mem_wr_data)
  );

  assign ent_map  = mem_rd_data[SLOT_W-1:0];
  assign ent_init = mem_rd_data[2*SLOT_W-1:SLOT_W];

  rsa_slot_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_slot_scan (
    .clk  (clk),
    .load (state_r == ST_SCAN),
    .occ  (occ_r),
    .hit  (mf_hit),
    .slot (mf_slot)
  );

  assign vok     = int'(item_r.virtual_reg) < NUM_VREGS;
  assign s_phys  = (ent_map != '0) && (int'(ent_map) < PHYS_END);
  assign s_p     = PHYS_W'(ent_map);
  assign fs_ok   = int'(item_r.fixed_slot) <= NUM_SLOTS;
  assign fs_phys = (item_r.fixed_slot != '0) && (int'(item_r.fixed_slot) < PHYS_END);
  assign fs_i    = SLOT_W'(item_r.fixed_slot);
  assign fs_p    = PHYS_W'(item_r.fixed_slot);

  // Physical slot searches over slots one to six
  always_comb begin
    pf_hit = 1'b0;
    pf_idx = '0;
    t1_hit = 1'b0;
    t1_idx = '0;
    t2_hit = 1'b0;
    t2_idx = '0;
    t_last = (rsa_cmd_t'(item_r.command) == CMD_TEMP_ANY) ? PHYS_END : LOW_TEMP_END;
    for (int i = PHYS_END - 1; i >= 1; i--) begin
      if (!occ_r[i]) begin
        pf_hit = 1'b1;
        pf_idx = PHYS_W'(i);
      end
      if (i < t_last && !occ_r[i] && !lt_r[i]) begin
        t1_hit = 1'b1;
        t1_idx = PHYS_W'(i);
      end
      if (i < t_last && !lv_r[i] && !lt_r[i]) begin
        t2_hit = 1'b1;
        t2_idx = PHYS_W'(i);
      end
    end
  end

  // Command execution: read-modify-write of the slot state
  always_comb begin
    occ_nxt     = occ_r;
    used_nxt    = used_r;
    mod_nxt     = mod_r;
    lv_nxt      = lv_r;
    lt_nxt      = lt_r;
    high_nxt    = high_r;
    res         = '0;
    mem_ctl     = '0;
    mem_ctl.wr_addr = item_r.virtual_reg;
    mem_wr_data = mem_rd_data;
    claim_hit   = 1'b0;
    claim_slot  = '0;
    init_new    = ent_init;
    temp_hit    = t1_hit || t2_hit;
    temp_idx    = t1_hit ? t1_idx : t2_idx;

    unique case (rsa_cmd_t'(item_r.command))
      CMD_MAP: begin
        if (vok) begin
          if (ent_map != '0) begin
            res.slot_index = FIELD_W'(ent_map);
            res.found      = 1'b1;
            if (s_phys) begin
              res.use_backup  = lt_r[s_p];
              res.is_physical = !lt_r[s_p];
              lv_nxt[s_p]     = 1'b1;
            end
            mod_nxt[ent_map] = 1'b1;
          end else if (pf_hit) begin
            claim_hit       = 1'b1;
            claim_slot      = SLOT_W'(pf_idx);
            res.use_backup  = lt_r[pf_idx];
            res.is_physical = !lt_r[pf_idx];
          end else if (mf_hit) begin
            claim_hit  = 1'b1;
            claim_slot = mf_slot;
          end
        end
      end
      CMD_UNMAP: begin
        if (vok && ent_map != '0) begin
          occ_nxt[ent_map] = 1'b0;
          if (s_phys) begin
            lv_nxt[s_p] = 1'b0;
            lt_nxt[s_p] = 1'b0;
          end
          mem_ctl.wr_en  = 1'b1;
          mem_wr_data    = {ent_init, {SLOT_W{1'b0}}};
          res.slot_index = FIELD_W'(ent_map);
          res.found      = 1'b1;
        end
      end
      CMD_UNLOCK_ALL: begin
        lv_nxt    = '0;
        lt_nxt    = '0;
        res.found = 1'b1;
      end
      CMD_TEMP_ANY, CMD_TEMP_LOW: begin
        if (temp_hit) begin
          lv_nxt[temp_idx]  = 1'b1;
          lt_nxt[temp_idx]  = 1'b1;
          mod_nxt[temp_idx] = 1'b1;
          res.slot_index    = FIELD_W'(temp_idx);
          res.found         = 1'b1;
          res.is_physical   = 1'b1;
          res.use_backup    = !t1_hit;
        end
      end
      CMD_RESERVE: begin
        if (fs_phys) begin
          res.use_backup  = occ_r[fs_i];
          lv_nxt[fs_p]    = 1'b1;
          lt_nxt[fs_p]    = 1'b1;
          mod_nxt[fs_i]   = 1'b1;
          res.slot_index  = item_r.fixed_slot;
          res.is_physical = 1'b1;
          res.found       = 1'b1;
        end
      end
      CMD_START_BLK: begin
        occ_nxt     = '0;
        used_nxt    = '0;
        lv_nxt      = '0;
        lt_nxt      = '0;
        mem_ctl.clr = 1'b1;
        if (!item_r.keep_modified) begin
          mod_nxt = '0;
        end
        res.found = 1'b1;
      end
      CMD_QUERY: begin
        if (fs_ok) begin
          res.in_use   = occ_r[fs_i];
          res.modified = mod_r[fs_i];
        end
        if (vok) begin
          res.slot_index   = FIELD_W'(ent_map);
          res.found        = (ent_map != '0);
          res.initial_slot = FIELD_W'(ent_init);
          if (s_phys) begin
            res.use_backup  = lt_r[s_p];
            res.is_physical = !lt_r[s_p];
          end
        end
      end
      default: res = '0;
    endcase

    if (claim_hit) begin
      if (item_r.for_reading && !used_r[claim_slot]) begin
        init_new = claim_slot;
      end
      used_nxt[claim_slot] = 1'b1;
      occ_nxt[claim_slot]  = 1'b1;
      mod_nxt[claim_slot]  = 1'b1;
      if (int'(claim_slot) < PHYS_END) begin
        lv_nxt[PHYS_W'(claim_slot)] = 1'b1;
      end
      if (claim_slot > high_r) begin
        high_nxt = claim_slot;
      end
      mem_ctl.wr_en  = 1'b1;
      mem_wr_data    = {init_new, claim_slot};
      res.slot_index = FIELD_W'(claim_slot);
      res.found      = 1'b1;
    end

    res.max_used = FIELD_W'(high_nxt);

    // Commit only in the execute cycle
    if (state_r != ST_EXEC) begin
      mem_ctl.wr_en = 1'b0;
      mem_ctl.clr   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      used_r      <= '0;
      mod_r       <= '0;
      lv_r        <= '0;
      lt_r        <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EXEC);
      if (state_r == ST_EXEC) begin
        occ_r  <= occ_nxt;
        used_r <= used_nxt;
        mod_r  <= mod_nxt;
        lv_r   <= lv_nxt;
        lt_r   <= lt_nxt;
        high_r <= high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
